// ----- rtl/ngg_pkg.sv -----
// ----------------------------------------------------------------------------
// ngg_pkg
// Shared types, widths, fixed-point constants and the arctangent table of the
// nearest-target go-to-goal controller.
// ----------------------------------------------------------------------------
package ngg_pkg;

    localparam int COORD_W    = 16;
    localparam int HEAD_W     = 16;
    localparam int ID_W       = 8;
    localparam int FUNC_W     = 2;
    localparam int GAIN_W     = 4;
    localparam int LIN_W      = 20;
    localparam int ANGSPD_W   = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIFF_W = COORD_W + 1;
    localparam int DIST_W = 33;
    localparam logic [DIST_W-1:0] DIST_EMPTY  = '1;
    localparam logic [DIST_W-1:0] SQ_BIT_INIT = {1'b1, {(DIST_W-1){1'b0}}};
    localparam int ROOT_W = DIST_W + 1;
    localparam int SQRT_W = 17;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS + 1);
    localparam int ATAN_IDX_W   = 5;
    localparam int CORDIC_W     = 28;
    localparam int ANG_W        = 28;
    localparam int PRE_SHIFT    = 8;
    localparam int ERR_W        = 30;
    localparam int HEAD_SHIFT   = 11;

    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int RND_SHIFT   = 11;
    localparam int RND_HALF    = 1024;
    localparam int LIN_MAX     = 1048575;
    localparam int ANG_MAX     = 524287;
    localparam int ANG_MIN     = -524288;
    localparam int PI_Q24      = 52707179;
    localparam int TWO_PI_Q24  = 105414357;
    localparam int HALF_PI_Q24 = 26353589;

    localparam logic                  NEAREST_RST  = 1'b1;
    localparam logic [COORD_W-1:0]    RADIUS_RST   = 16'd2048;
    localparam logic [GAIN_W-1:0]     LIN_GAIN_RST = 4'd2;
    localparam logic [GAIN_W-1:0]     ANG_GAIN_RST = 4'd6;

    localparam logic [FUNC_W-1:0] FUNC_POSE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CAND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAREST_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CATCH_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_GAIN = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [COORD_W-1:0]       coord_x;
        logic [COORD_W-1:0]       coord_y;
        logic signed [HEAD_W-1:0] heading;
        logic [ID_W-1:0]          target_id;
        logic                     first_in_list;
        logic                     last_in_list;
    } in_item_t;

    typedef struct packed {
        logic [LIN_W-1:0]           linear_speed;
        logic signed [ANGSPD_W-1:0] angular_speed;
        logic                       caught;
        logic [ID_W-1:0]            caught_id;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DX2,
        ST_DY2,
        ST_SUM,
        ST_CMP,
        ST_ITER,
        ST_LIN,
        ST_ANG,
        ST_RND,
        ST_OUT
    } ngg_state_t;

    function automatic logic signed [ANG_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] val;
        unique case (idx)
            5'd0:    val = ANG_W'(13176795);
            5'd1:    val = ANG_W'(7778716);
            5'd2:    val = ANG_W'(4110060);
            5'd3:    val = ANG_W'(2086331);
            5'd4:    val = ANG_W'(1047214);
            5'd5:    val = ANG_W'(524117);
            5'd6:    val = ANG_W'(262123);
            5'd7:    val = ANG_W'(131069);
            5'd8:    val = ANG_W'(65536);
            5'd9:    val = ANG_W'(32768);
            5'd10:   val = ANG_W'(16384);
            5'd11:   val = ANG_W'(8192);
            5'd12:   val = ANG_W'(4096);
            5'd13:   val = ANG_W'(2048);
            5'd14:   val = ANG_W'(1024);
            5'd15:   val = ANG_W'(512);
            5'd16:   val = ANG_W'(256);
            5'd17:   val = ANG_W'(128);
            5'd18:   val = ANG_W'(64);
            5'd19:   val = ANG_W'(32);
            5'd20:   val = ANG_W'(16);
            5'd21:   val = ANG_W'(8);
            5'd22:   val = ANG_W'(4);
            5'd23:   val = ANG_W'(2);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/nearest_target_go_to_goal.sv -----
// ----------------------------------------------------------------------------
// nearest_target_go_to_goal
// Candidate selection and proportional go-to-goal control on pose, candidate
// and tick events, with a shared multiplier, a bit-pair square root and an
// iterative CORDIC.
// ----------------------------------------------------------------------------
// A pose update is taken in ST_IDLE and a candidate target passes through
// ST_DX2, ST_DY2 and ST_SUM (two squares on the shared 31x18 multiplier and
// one add). A control tick that finds the goal within the catch radius goes
// on through ST_CMP to ST_OUT. Any other acting tick runs the 17-step square
// root and the CORDIC (sixteen steps by default) side by side in ST_ITER; the
// multiplier then forms both speed commands in turn. Ticks before a pose and
// a goal exist, and the unused event code, are taken in ST_IDLE and give no
// result. The input is stalled while an item is in work; a finished result
// that waits in the output register holds up only the next result, in ST_OUT.
// ----------------------------------------------------------------------------
module nearest_target_go_to_goal
    import ngg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  in_item_t                item,
    output logic                    result_valid,
    input  logic                    result_stall,
    output out_item_t               result,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam logic signed [MUL_P_W-1:0] LIN_HI    = MUL_P_W'(LIN_MAX);
    localparam logic signed [MUL_P_W-1:0] ANG_HI    = MUL_P_W'(ANG_MAX);
    localparam logic signed [MUL_P_W-1:0] ANG_LO    = MUL_P_W'(ANG_MIN);
    localparam logic signed [MUL_P_W-1:0] RND_P     = MUL_P_W'(RND_HALF);
    localparam logic signed [ERR_W-1:0]   PI_E      = ERR_W'(PI_Q24);
    localparam logic signed [ERR_W-1:0]   NEG_PI_E  = -ERR_W'(PI_Q24);
    localparam logic signed [ERR_W-1:0]   TWO_PI_E  = ERR_W'(TWO_PI_Q24);

    ngg_state_t                  state_reg;
    ngg_state_t                  state_next;

    logic                        nearest_mode_reg;
    logic [COORD_W-1:0]          catch_radius_reg;
    logic [GAIN_W-1:0]           linear_gain_reg;
    logic [GAIN_W-1:0]           angular_gain_reg;

    logic [COORD_W-1:0]          own_x_reg;
    logic [COORD_W-1:0]          own_y_reg;
    logic signed [HEAD_W-1:0]    own_heading_reg;
    logic                        pose_seen_reg;
    logic                        goal_valid_reg;
    logic [COORD_W-1:0]          goal_x_reg;
    logic [COORD_W-1:0]          goal_y_reg;
    logic [ID_W-1:0]             goal_id_reg;
    logic [COORD_W-1:0]          best_x_reg;
    logic [COORD_W-1:0]          best_y_reg;
    logic [ID_W-1:0]             best_id_reg;
    logic [DIST_W-1:0]           best_dist_sq_reg;

    in_item_t                    item_reg;
    logic signed [DIFF_W-1:0]    dx_reg;
    logic signed [DIFF_W-1:0]    dy_reg;
    logic signed [MUL_P_W-1:0]   prod_reg;
    logic [DIST_W-1:0]           acc_reg;
    logic [DIST_W-1:0]           dsq_reg;
    logic [DIST_W-1:0]           sq_rem_reg;
    logic [ROOT_W-1:0]           sq_root_reg;
    logic [DIST_W-1:0]           sq_bit_reg;
    logic signed [ERR_W-1:0]     err_reg;
    out_item_t                   res_reg;
    out_item_t                   result_reg;
    logic                        result_valid_reg;

    logic                        item_accept;
    logic                        result_load;
    logic                        cordic_start;
    logic                        cordic_done;
    logic signed [ANG_W-1:0]     cordic_angle;
    logic [COORD_W-1:0]          src_x;
    logic [COORD_W-1:0]          src_y;
    logic signed [DIFF_W-1:0]    diff_x;
    logic signed [DIFF_W-1:0]    diff_y;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic [DIST_W-1:0]           d_sum;
    logic [DIST_W-1:0]           held;
    logic                        take;
    logic                        is_cand;
    logic                        caught_hit;
    logic [ROOT_W-1:0]           sq_trial;
    logic                        sq_fit;
    logic signed [ERR_W-1:0]     err_raw;
    logic signed [ERR_W-1:0]     err_wrap;
    logic [LIN_W-1:0]            lin_sat;
    logic signed [MUL_P_W-1:0]   ang_q;
    logic signed [ANGSPD_W-1:0]  ang_sat;

    assign item_accept  = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign src_x  = (item.func == FUNC_CAND) ? item.coord_x : goal_x_reg;
    assign src_y  = (item.func == FUNC_CAND) ? item.coord_y : goal_y_reg;
    assign diff_x = $signed({1'b0, src_x}) - $signed({1'b0, own_x_reg});
    assign diff_y = $signed({1'b0, src_y}) - $signed({1'b0, own_y_reg});

    assign mul_p = mul_a * mul_b;
    assign d_sum = acc_reg + prod_reg[DIST_W-1:0];

    assign is_cand    = (item_reg.func == FUNC_CAND);
    assign held       = item_reg.first_in_list ? DIST_EMPTY : best_dist_sq_reg;
    assign take       = nearest_mode_reg ? (d_sum < held) : (held == DIST_EMPTY);
    assign caught_hit = (dsq_reg <= prod_reg[DIST_W-1:0]);

    assign sq_trial = sq_root_reg + ROOT_W'(sq_bit_reg);
    assign sq_fit   = ({1'b0, sq_rem_reg} >= sq_trial);

    assign err_raw = {{(ERR_W-ANG_W){cordic_angle[ANG_W-1]}}, cordic_angle}
                   - {{(ERR_W-HEAD_W-HEAD_SHIFT){own_heading_reg[HEAD_W-1]}},
                      own_heading_reg, {HEAD_SHIFT{1'b0}}};

    always_comb
    begin
        priority if (err_raw > PI_E)
            err_wrap = err_raw - TWO_PI_E;
        else if (err_raw < NEG_PI_E)
            err_wrap = err_raw + TWO_PI_E;
        else
            err_wrap = err_raw;
    end

    assign lin_sat = (prod_reg > LIN_HI) ? LIN_W'(LIN_MAX) : prod_reg[LIN_W-1:0];
    assign ang_q   = (prod_reg + RND_P) >>> RND_SHIFT;

    always_comb
    begin
        priority if (ang_q > ANG_HI)
            ang_sat = ANGSPD_W'(ANG_MAX);
        else if (ang_q < ANG_LO)
            ang_sat = ANGSPD_W'(ANG_MIN);
        else
            ang_sat = ang_q[ANGSPD_W-1:0];
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DX2:
            begin
                mul_a = {{(MUL_A_W-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg};
                mul_b = {{(MUL_B_W-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg};
            end
            ST_DY2:
            begin
                mul_a = {{(MUL_A_W-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg};
                mul_b = {{(MUL_B_W-DIFF_W){dy_reg[DIFF_W-1]}}, dy_reg};
            end
            ST_SUM:
            begin
                mul_a = {{(MUL_A_W-COORD_W){1'b0}}, catch_radius_reg};
                mul_b = {{(MUL_B_W-COORD_W){1'b0}}, catch_radius_reg};
            end
            ST_LIN:
            begin
                mul_a = {{(MUL_A_W-SQRT_W){1'b0}}, sq_root_reg[SQRT_W-1:0]};
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, linear_gain_reg};
            end
            ST_ANG:
            begin
                mul_a = {{(MUL_A_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                mul_b = {{(MUL_B_W-GAIN_W){1'b0}}, angular_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ngg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        item_stall   = 1'b1;
        cordic_start = 1'b0;
        result_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    unique case (item.func)
                        FUNC_CAND:
                            state_next = ST_DX2;
                        FUNC_TICK:
                            if (pose_seen_reg && goal_valid_reg)
                                state_next = ST_DX2;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DX2:
                state_next = ST_DY2;
            ST_DY2:
                state_next = ST_SUM;
            ST_SUM:
                state_next = is_cand ? ST_IDLE : ST_CMP;
            ST_CMP:
            begin
                if (caught_hit)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cordic_start = 1'b1;
                    state_next   = ST_ITER;
                end
            end
            ST_ITER:
                if ((sq_bit_reg == '0) && cordic_done)
                    state_next = ST_LIN;
            ST_LIN:
                state_next = ST_ANG;
            ST_ANG:
                state_next = ST_RND;
            ST_RND:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nearest_mode_reg <= NEAREST_RST;
            catch_radius_reg <= RADIUS_RST;
            linear_gain_reg  <= LIN_GAIN_RST;
            angular_gain_reg <= ANG_GAIN_RST;
            own_x_reg        <= '0;
            own_y_reg        <= '0;
            own_heading_reg  <= '0;
            pose_seen_reg    <= 1'b0;
            goal_valid_reg   <= 1'b0;
            goal_x_reg       <= '0;
            goal_y_reg       <= '0;
            goal_id_reg      <= '0;
            best_x_reg       <= '0;
            best_y_reg       <= '0;
            best_id_reg      <= '0;
            best_dist_sq_reg <= DIST_EMPTY;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NEAREST_MODE: nearest_mode_reg <= cfg_data[0];
                    CFG_CATCH_RADIUS: catch_radius_reg <= cfg_data;
                    CFG_LINEAR_GAIN:  linear_gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_ANGULAR_GAIN: angular_gain_reg <= cfg_data[GAIN_W-1:0];
                    default:          nearest_mode_reg <= nearest_mode_reg;
                endcase
            end

            if (item_accept && (item.func == FUNC_POSE))
            begin
                own_x_reg       <= item.coord_x;
                own_y_reg       <= item.coord_y;
                own_heading_reg <= item.heading;
                pose_seen_reg   <= 1'b1;
            end

            // keep or replace the held candidate, commit on the last one
            if ((state_reg == ST_SUM) && is_cand)
            begin
                if (take)
                begin
                    best_x_reg  <= item_reg.coord_x;
                    best_y_reg  <= item_reg.coord_y;
                    best_id_reg <= item_reg.target_id;
                end
                priority if (item_reg.last_in_list)
                    best_dist_sq_reg <= DIST_EMPTY;
                else if (take)
                    best_dist_sq_reg <= d_sum;
                else
                    best_dist_sq_reg <= held;
                if (item_reg.last_in_list)
                begin
                    goal_x_reg     <= take ? item_reg.coord_x : best_x_reg;
                    goal_y_reg     <= take ? item_reg.coord_y : best_y_reg;
                    goal_id_reg    <= take ? item_reg.target_id : best_id_reg;
                    goal_valid_reg <= 1'b1;
                end
            end

            if ((state_reg == ST_CMP) && caught_hit)
            begin
                goal_valid_reg <= 1'b0;
            end

            if (result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;

        if (item_accept)
        begin
            item_reg <= item;
            dx_reg   <= diff_x;
            dy_reg   <= diff_y;
        end

        if (state_reg == ST_DY2)
        begin
            acc_reg <= prod_reg[DIST_W-1:0];
        end

        if (state_reg == ST_SUM)
        begin
            dsq_reg <= d_sum;
        end

        if (state_reg == ST_CMP)
        begin
            if (caught_hit)
            begin
                res_reg.linear_speed  <= '0;
                res_reg.angular_speed <= '0;
                res_reg.caught        <= 1'b1;
                res_reg.caught_id     <= goal_id_reg;
            end
            else
            begin
                sq_rem_reg  <= dsq_reg;
                sq_root_reg <= '0;
                sq_bit_reg  <= SQ_BIT_INIT;
            end
        end

        if ((state_reg == ST_ITER) && (sq_bit_reg != '0))
        begin
            if (sq_fit)
            begin
                sq_rem_reg  <= sq_rem_reg - sq_trial[DIST_W-1:0];
                sq_root_reg <= (sq_root_reg >> 1) + ROOT_W'(sq_bit_reg);
            end
            else
            begin
                sq_root_reg <= sq_root_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end

        if (state_reg == ST_LIN)
        begin
            err_reg <= err_wrap;
        end

        if (state_reg == ST_ANG)
        begin
            res_reg.linear_speed <= lin_sat;
        end

        if (state_reg == ST_RND)
        begin
            res_reg.angular_speed <= ang_sat;
            res_reg.caught        <= 1'b0;
            res_reg.caught_id     <= '0;
        end

        if (result_load)
        begin
            result_reg <= res_reg;
        end
    end

    a_caught_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.caught) |->
        ((result_reg.linear_speed == '0) && (result_reg.angular_speed == '0)))
        else $error("caught result carries nonzero speed");

    a_id_only_on_catch: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.caught) |-> (result_reg.caught_id == '0))
        else $error("caught_id set without a catch");

    a_commit_clears_best: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SUM) && is_cand && item_reg.last_in_list) |=>
        ((best_dist_sq_reg == DIST_EMPTY) && goal_valid_reg))
        else $error("commit did not set goal and clear held candidate");

    a_catch_drops_goal: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CMP) && caught_hit) |=> !goal_valid_reg)
        else $error("goal kept after catch");

    a_iter_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LIN) |-> ((sq_bit_reg == '0) && cordic_done))
        else $error("speed stage entered before root and bearing are done");

endmodule

// ----- rtl/ngg_cordic.sv -----
// ----------------------------------------------------------------------------
// ngg_cordic
// Iterative CORDIC vectoring unit: one micro-rotation per cycle, returns the
// angle of (dx, dy) in units of 2^-24 rad.
// ----------------------------------------------------------------------------
module ngg_cordic
    import ngg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [DIFF_W-1:0]   dx,
    input  logic signed [DIFF_W-1:0]   dy,
    output logic                       done,
    output logic signed [ANG_W-1:0]    angle
);

    localparam int EXT_W = CORDIC_W - DIFF_W - PRE_SHIFT;

    logic                          run_reg;
    logic [CORDIC_CNT_W-1:0]       step_reg;
    logic signed [CORDIC_W-1:0]    x_reg;
    logic signed [CORDIC_W-1:0]    y_reg;
    logic signed [ANG_W-1:0]       z_reg;

    logic signed [CORDIC_W-1:0]    x_in;
    logic signed [CORDIC_W-1:0]    y_in;
    logic signed [CORDIC_W-1:0]    x_shift;
    logic signed [CORDIC_W-1:0]    y_shift;
    logic signed [ANG_W-1:0]       atan_val;
    logic                          last_step;

    assign x_in      = {{EXT_W{dx[DIFF_W-1]}}, dx, {PRE_SHIFT{1'b0}}};
    assign y_in      = {{EXT_W{dy[DIFF_W-1]}}, dy, {PRE_SHIFT{1'b0}}};
    assign x_shift   = x_reg >>> step_reg;
    assign y_shift   = y_reg >>> step_reg;
    assign atan_val  = atan_q24(ATAN_IDX_W'(step_reg));
    assign last_step = (step_reg == CORDIC_CNT_W'(CORDIC_STEPS - 1));
    assign done      = !run_reg;
    assign angle     = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            step_reg <= '0;
        end
        else if (run_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (last_step)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    // pre-rotate the left half-plane, then micro-rotate toward the x axis
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg <= y_in;
                    y_reg <= -x_in;
                    z_reg <= ANG_W'(HALF_PI_Q24);
                end
                else
                begin
                    x_reg <= -y_in;
                    y_reg <= x_in;
                    z_reg <= -ANG_W'(HALF_PI_Q24);
                end
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        else if (run_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + y_shift;
                y_reg <= y_reg - x_shift;
                z_reg <= z_reg + atan_val;
            end
            else
            begin
                x_reg <= x_reg - y_shift;
                y_reg <= y_reg + x_shift;
                z_reg <= z_reg - atan_val;
            end
        end
    end

endmodule
